// ----- design/vesp_pkg.sv -----
// Shared constants, codes and interface types of the escape sequence parser.
`timescale 1ns / 1ps

package vesp_pkg;

    // String buffer geometry.
    localparam int BUF_DEPTH = 32;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);
    localparam int LEN_W     = $clog2(BUF_DEPTH + 1);

    // Bytes with a fixed meaning to the parser.
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_DCS   = 8'h50;
    localparam logic [7:0] CH_CSI   = 8'h5b;
    localparam logic [7:0] CH_OSC   = 8'h5d;
    localparam logic [7:0] CH_CAN   = 8'h18;
    localparam logic [7:0] CH_SUB   = 8'h1a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_DEL   = 8'h7f;

    typedef enum logic [3:0] {
        MODE_GROUND,
        MODE_DCS,
        MODE_DCS_INT,
        MODE_DCS_PAR,
        MODE_DCS_PASS,
        MODE_DCS_IGN,
        MODE_OSC,
        MODE_CSI,
        MODE_CSI_INT,
        MODE_CSI_PAR,
        MODE_CSI_IGN
    } t_mode;

    typedef enum logic [2:0] {
        EV_PRINT,
        EV_CSI,
        EV_DCS_HDR,
        EV_DCS_BYTE,
        EV_DCS_END,
        EV_OSC
    } t_event;

    // What comes first among the results of one input byte.
    typedef enum logic [1:0] {
        HEAD_NONE,
        HEAD_DCS_END,
        HEAD_STRING
    } t_head;

    typedef enum logic [1:0] {
        OSEL_DIRECT,
        OSEL_TAIL,
        OSEL_STREAM
    } t_out_sel;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SEND,
        ST_TAIL
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic     accept;
        logic     rd_first;
        logic     rd_next;
        logic     out_load;
        t_out_sel out_sel;
        logic     out_last;
        logic     out_pop;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_head head;
        logic  head_empty;
        logic  tail;
        logic  tail_pend;
        logic  str_last;
        logic  out_valid;
    } t_dp_sts;

endpackage

// ----- design/vesp_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
`timescale 1ns / 1ps

module vesp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- design/vesp_dp.sv -----
// Datapath: parser state, byte decode, string buffer, stream counter and output register.
`timescale 1ns / 1ps

module vesp_dp import vesp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_input_byte,
    input  t_dp_cmd    i_cmd,
    output t_dp_sts    o_sts,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_run,
    output logic       o_string_overflow
);

    // Parser state.
    t_mode             r_mode, n_mode;
    logic              r_esc, n_esc;
    logic [LEN_W-1:0]  r_len, n_len;
    logic              r_ovf, n_ovf;

    // Decode of the current byte.
    logic              c_ctl, c_inter, c_param, c_fin, c_digit, c_high;
    logic              v_put, v_go, v_csi_fin, v_tail;
    t_mode             v_go_mode;
    t_event            v_tail_kind;
    logic [LEN_W-1:0]  v_len;
    logic              v_ovf;
    t_head             v_head;
    t_event            v_head_kind;
    logic [LEN_W-1:0]  v_head_len;
    logic              v_head_ovf;
    logic              w_wr_en;

    // Latched for streaming and the trailing result.
    t_event            r_str_kind;
    logic [LEN_W-1:0]  r_str_len;
    logic              r_str_ovf;
    logic              r_tail;
    t_event            r_tail_kind;
    logic [7:0]        r_tail_byte;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [7:0]        w_rd_data;

    // Output register.
    logic              r_out_valid;
    t_event            r_out_kind;
    logic [7:0]        r_out_byte;
    logic              r_out_bvalid;
    logic              r_out_last;
    logic              r_out_ovf;

    always_comb begin
        c_ctl   = (i_input_byte < 8'h20);
        c_inter = (i_input_byte inside {[8'h20:8'h2f]});
        c_param = (i_input_byte inside {[8'h30:8'h3f]});
        c_fin   = (i_input_byte inside {[8'h40:8'h7e]});
        c_digit = (i_input_byte inside {[8'h30:8'h39], 8'h3b});
        c_high  = i_input_byte[7];
    end

    // Action decode of one byte against the current mode.
    always_comb begin
        v_put       = 1'b0;
        v_go        = 1'b0;
        v_go_mode   = MODE_GROUND;
        v_csi_fin   = 1'b0;
        v_tail      = 1'b0;
        v_tail_kind = EV_PRINT;
        n_esc       = r_esc;
        if (i_input_byte == CH_ESC) begin
            n_esc = 1'b1;
        end else if (r_esc) begin
            n_esc = 1'b0;
            v_go  = 1'b1;
            case (i_input_byte)
                CH_DCS:  v_go_mode = MODE_DCS;
                CH_CSI:  v_go_mode = MODE_CSI;
                CH_OSC:  v_go_mode = MODE_OSC;
                default: v_go_mode = MODE_GROUND;
            endcase
        end else if (i_input_byte == CH_CAN || i_input_byte == CH_SUB) begin
            // Forced return to ground; ground then prints the byte.
            v_go   = 1'b1;
            v_tail = 1'b1;
        end else begin
            case (r_mode)
                MODE_GROUND: begin
                    v_tail = 1'b1;
                end
                MODE_DCS: begin
                    if (c_inter) begin
                        v_put = 1'b1; v_go = 1'b1; v_go_mode = MODE_DCS_INT;
                    end else if (i_input_byte == CH_COLON) begin
                        v_go = 1'b1; v_go_mode = MODE_DCS_IGN;
                    end else if (c_param) begin
                        v_put = 1'b1; v_go = 1'b1; v_go_mode = MODE_DCS_PAR;
                    end else if (c_fin) begin
                        v_put = 1'b1; v_go = 1'b1; v_go_mode = MODE_DCS_PASS;
                    end
                end
                MODE_DCS_INT: begin
                    if (c_inter) begin
                        v_put = 1'b1;
                    end else if (c_param) begin
                        v_go = 1'b1; v_go_mode = MODE_DCS_IGN;
                    end else if (c_fin) begin
                        v_put = 1'b1; v_go = 1'b1; v_go_mode = MODE_DCS_PASS;
                    end
                end
                MODE_DCS_PAR: begin
                    if (c_inter) begin
                        v_put = 1'b1; v_go = 1'b1; v_go_mode = MODE_DCS_INT;
                    end else if (c_digit) begin
                        v_put = 1'b1;
                    end else if (c_param) begin
                        v_go = 1'b1; v_go_mode = MODE_DCS_IGN;
                    end else if (c_fin) begin
                        v_put = 1'b1; v_go = 1'b1; v_go_mode = MODE_DCS_PASS;
                    end
                end
                MODE_DCS_PASS: begin
                    if (i_input_byte != CH_DEL) begin
                        v_tail = 1'b1; v_tail_kind = EV_DCS_BYTE;
                    end
                end
                MODE_OSC: begin
                    v_put = !c_ctl;
                end
                MODE_CSI: begin
                    if (c_ctl) begin
                        v_tail = 1'b1;
                    end else if (c_inter) begin
                        v_put = 1'b1; v_go = 1'b1; v_go_mode = MODE_CSI_INT;
                    end else if (i_input_byte == CH_COLON) begin
                        v_go = 1'b1; v_go_mode = MODE_CSI_IGN;
                    end else if (c_param) begin
                        v_put = 1'b1; v_go = 1'b1; v_go_mode = MODE_CSI_PAR;
                    end else if (c_fin) begin
                        v_tail = 1'b1; v_tail_kind = EV_CSI; v_go = 1'b1;
                    end
                end
                MODE_CSI_INT: begin
                    if (c_ctl) begin
                        v_tail = 1'b1;
                    end else if (c_inter) begin
                        v_put = 1'b1;
                    end else if (c_param) begin
                        v_go = 1'b1; v_go_mode = MODE_CSI_IGN;
                    end else if (c_fin) begin
                        v_put = 1'b1; v_csi_fin = 1'b1; v_go = 1'b1;
                    end
                end
                MODE_CSI_PAR: begin
                    if (c_ctl) begin
                        v_tail = 1'b1;
                    end else if (c_inter) begin
                        v_put = 1'b1; v_go = 1'b1; v_go_mode = MODE_CSI_INT;
                    end else if (c_digit) begin
                        v_put = 1'b1;
                    end else if (c_param) begin
                        v_go = 1'b1; v_go_mode = MODE_CSI_IGN;
                    end else if (c_fin) begin
                        v_put = 1'b1; v_csi_fin = 1'b1; v_go = 1'b1;
                    end
                end
                MODE_CSI_IGN: begin
                    if (c_ctl) begin
                        v_tail = 1'b1;
                    end else if (c_fin || c_high) begin
                        v_go = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Buffer append, string emission and the exit and entry actions of a mode change.
    always_comb begin
        v_len       = r_len;
        v_ovf       = r_ovf;
        w_wr_en     = 1'b0;
        v_head      = HEAD_NONE;
        v_head_kind = EV_OSC;
        v_head_len  = r_len;
        v_head_ovf  = r_ovf;
        n_mode      = r_mode;
        if (v_put) begin
            if (r_len < LEN_W'(BUF_DEPTH)) begin
                w_wr_en = 1'b1;
                v_len   = r_len + LEN_W'(1);
            end else begin
                v_ovf = 1'b1;
            end
        end
        if (v_csi_fin) begin
            v_head      = HEAD_STRING;
            v_head_kind = EV_CSI;
            v_head_len  = v_len;
            v_head_ovf  = v_ovf;
            v_len       = '0;
            v_ovf       = 1'b0;
        end
        if (v_go) begin
            if (r_mode == MODE_DCS_PASS) begin
                v_head = HEAD_DCS_END;
            end else if (r_mode == MODE_OSC) begin
                v_head      = HEAD_STRING;
                v_head_kind = EV_OSC;
                v_head_len  = v_len;
                v_head_ovf  = v_ovf;
                v_len       = '0;
                v_ovf       = 1'b0;
            end
            if (v_go_mode == MODE_GROUND) begin
                v_len = '0;
                v_ovf = 1'b0;
            end else if (v_go_mode == MODE_DCS_PASS) begin
                v_head      = HEAD_STRING;
                v_head_kind = EV_DCS_HDR;
                v_head_len  = v_len;
                v_head_ovf  = v_ovf;
                v_len       = '0;
                v_ovf       = 1'b0;
            end
            n_mode = v_go_mode;
        end
        n_len = v_len;
        n_ovf = v_ovf;
    end

    vesp_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en && i_cmd.accept),
        .i_wr_addr (r_len[ADDR_W-1:0]),
        .i_wr_data (i_input_byte),
        .i_rd_en   (i_cmd.rd_first || i_cmd.rd_next),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_addr = i_cmd.rd_first ? '0 : r_idx + ADDR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_GROUND;
            r_esc       <= 1'b0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_tail      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_mode <= n_mode;
                r_esc  <= n_esc;
                r_len  <= n_len;
                r_ovf  <= n_ovf;
                r_tail <= v_tail;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.out_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_str_kind  <= v_head_kind;
            r_str_len   <= v_head_len;
            r_str_ovf   <= v_head_ovf;
            r_tail_kind <= v_tail_kind;
            r_tail_byte <= i_input_byte;
        end
        if (i_cmd.rd_first) begin
            r_idx <= '0;
        end else if (i_cmd.rd_next) begin
            r_idx <= r_idx + ADDR_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_last <= i_cmd.out_last;
            case (i_cmd.out_sel)
                OSEL_DIRECT: begin
                    case (v_head)
                        HEAD_DCS_END: begin
                            r_out_kind   <= EV_DCS_END;
                            r_out_byte   <= 8'h00;
                            r_out_bvalid <= 1'b0;
                            r_out_ovf    <= 1'b0;
                        end
                        HEAD_STRING: begin
                            r_out_kind   <= v_head_kind;
                            r_out_byte   <= 8'h00;
                            r_out_bvalid <= 1'b0;
                            r_out_ovf    <= v_head_ovf;
                        end
                        default: begin
                            r_out_kind   <= v_tail_kind;
                            r_out_byte   <= i_input_byte;
                            r_out_bvalid <= 1'b1;
                            r_out_ovf    <= 1'b0;
                        end
                    endcase
                end
                OSEL_TAIL: begin
                    r_out_kind   <= r_tail_kind;
                    r_out_byte   <= r_tail_byte;
                    r_out_bvalid <= 1'b1;
                    r_out_ovf    <= 1'b0;
                end
                default: begin
                    r_out_kind   <= r_str_kind;
                    r_out_byte   <= w_rd_data;
                    r_out_bvalid <= 1'b1;
                    r_out_ovf    <= r_str_ovf;
                end
            endcase
        end
    end

    always_comb begin
        o_sts.head       = v_head;
        o_sts.head_empty = (v_head_len == '0);
        o_sts.tail       = v_tail;
        o_sts.tail_pend  = r_tail;
        o_sts.str_last   = ((LEN_W'(r_idx) + LEN_W'(1)) == r_str_len);
        o_sts.out_valid  = r_out_valid;
    end

    assign o_event_kind      = r_out_kind;
    assign o_data_byte       = r_out_byte;
    assign o_byte_valid      = r_out_bvalid;
    assign o_last_of_run     = r_out_last;
    assign o_string_overflow = r_out_ovf;

endmodule

// ----- design/vesp_ctrl.sv -----
// Controller: sequences the results of each accepted byte onto the output register.
`timescale 1ns / 1ps

module vesp_ctrl import vesp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_in_stall
);

    t_state r_state, n_state;
    logic   w_out_ready;

    // The output register can take a result when empty or when its result leaves now.
    assign w_out_ready = !i_sts.out_valid || !i_out_stall;
    assign o_in_stall  = !((r_state == ST_IDLE) && w_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_cmd.out_sel = OSEL_DIRECT;
        // The result in the output register leaves at this edge.
        o_cmd.out_pop = i_sts.out_valid && !i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && w_out_ready) begin
                    o_cmd.accept = 1'b1;
                    case (i_sts.head)
                        HEAD_NONE: begin
                            o_cmd.out_load = i_sts.tail;
                            o_cmd.out_last = 1'b1;
                        end
                        HEAD_DCS_END: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = !i_sts.tail;
                            if (i_sts.tail) begin
                                n_state = ST_TAIL;
                            end
                        end
                        HEAD_STRING: begin
                            if (i_sts.head_empty) begin
                                o_cmd.out_load = 1'b1;
                                o_cmd.out_last = !i_sts.tail;
                                if (i_sts.tail) begin
                                    n_state = ST_TAIL;
                                end
                            end else begin
                                n_state = ST_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                o_cmd.rd_first = 1'b1;
                n_state        = ST_SEND;
            end
            ST_SEND: begin
                if (w_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_STREAM;
                    o_cmd.out_last = i_sts.str_last && !i_sts.tail_pend;
                    if (!i_sts.str_last) begin
                        o_cmd.rd_next = 1'b1;
                    end else begin
                        n_state = i_sts.tail_pend ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL: begin
                if (w_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_TAIL;
                    o_cmd.out_last = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/vt_escape_sequence_parser.sv -----
// Top level of the terminal escape sequence parser.
//
//   channel   direction   handshake                     payload
//   in        request in  i_in_valid / o_in_stall       i_input_byte
//   out       result out  o_out_valid / i_out_stall     o_event_kind, o_data_byte,
//                                                       o_byte_valid, o_last_of_run,
//                                                       o_string_overflow
//
// A byte that causes at most one result, or nothing, is taken without holding off the
// input, so plain text passes at one byte per cycle when the output does not stall. A
// byte that closes a non-empty string of N buffered bytes holds the input for a buffer
// read, one byte per cycle from its single read port unless stalled, then any print.
// Reset is synchronous and active low; the buffer needs no clearing pass after reset.
// A stall on the output holds the output register and, while a result waits there,
// also stalls the input.
//
// Results of one request leave in order; the last of them carries o_last_of_run.
`timescale 1ns / 1ps

module vt_escape_sequence_parser import vesp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_input_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_event_kind,
    output logic [7:0] o_data_byte,
    output logic       o_byte_valid,
    output logic       o_last_of_run,
    output logic       o_string_overflow
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // The controller owns sequencing: when a request is taken, when the buffer is read
    // and which source feeds the output register.
    vesp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall)
    );

    // The datapath holds the parser mode, the escape flag, the string buffer with its
    // length and overflow flag, and the output register.
    vesp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_input_byte      (i_input_byte),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_event_kind      (o_event_kind),
        .o_data_byte       (o_data_byte),
        .o_byte_valid      (o_byte_valid),
        .o_last_of_run     (o_last_of_run),
        .o_string_overflow (o_string_overflow)
    );

    assign o_out_valid = w_sts.out_valid;

    // A request is never taken while a result sits blocked in the output register.
    a_no_accept_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |-> !(o_out_valid && i_out_stall))
        else $error("request taken while output blocked");

    // The output register is only loaded when its current result is gone or leaving.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("output register overwritten");

    // A request that closes a non-empty string holds off the next request.
    a_string_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.accept && w_sts.head == HEAD_STRING && !w_sts.head_empty) |=> o_in_stall)
        else $error("input open during string stream");

endmodule

// ----- bench/esc_parser_checker.sv -----
// Checker for the escape sequence parser: predicts the results of every request and compares.
`timescale 1ns / 1ps

module esc_parser_checker import vesp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_input_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [2:0] i_event_kind,
    input  logic [7:0] i_data_byte,
    input  logic       i_byte_valid,
    input  logic       i_last_of_run,
    input  logic       i_string_overflow,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        t_event     kind;
        logic [7:0] data;
        logic       has_byte;
        logic       last;
        logic       overflow;
    } parse_event_t;

    // Shadow copy of the parser state.
    t_mode            mode;
    logic             esc_seen;
    logic [7:0]       str_buf [BUF_DEPTH];
    logic [LEN_W-1:0] str_len;
    logic             str_ovf;

    parse_event_t expected_events [$];
    parse_event_t request_events [$];

    initial o_fail_count = 0;
    initial o_pending = 0;

    task automatic push_event(input t_event kind, input logic [7:0] data,
                              input logic has_byte, input logic ovf);
        parse_event_t ev;
        ev.kind     = kind;
        ev.data     = data;
        ev.has_byte = has_byte;
        ev.last     = 1'b0;
        ev.overflow = ovf;
        request_events.push_back(ev);
    endtask

    task automatic push_string(input t_event kind);
        if (str_len == 0) begin
            push_event(kind, 8'h00, 1'b0, str_ovf);
        end else begin
            for (int i = 0; i < str_len; i++)
                push_event(kind, str_buf[i], 1'b1, str_ovf);
        end
    endtask

    task automatic buffer_byte(input logic [7:0] ch);
        if (str_len < BUF_DEPTH) begin
            str_buf[str_len] = ch;
            str_len = str_len + 1'b1;
        end else begin
            str_ovf = 1'b1;
        end
    endtask

    task automatic clear_string();
        str_len = '0;
        str_ovf = 1'b0;
    endtask

    // Exit action of the old mode, then entry action of the new one, even when equal.
    task automatic enter_mode(input t_mode next);
        if (mode == MODE_DCS_PASS) begin
            push_event(EV_DCS_END, 8'h00, 1'b0, 1'b0);
        end else if (mode == MODE_OSC) begin
            push_string(EV_OSC);
            clear_string();
        end
        if (next == MODE_GROUND) begin
            clear_string();
        end else if (next == MODE_DCS_PASS) begin
            push_string(EV_DCS_HDR);
            clear_string();
        end
        mode = next;
    endtask

    task automatic finish_csi(input logic [7:0] ch);
        buffer_byte(ch);
        push_string(EV_CSI);
        clear_string();
        enter_mode(MODE_GROUND);
    endtask

    task automatic mode_byte(input logic [7:0] ch);
        logic ctl;
        logic inter;
        logic param;
        logic fin;
        logic plain_param;
        ctl         = ch < 8'h20;
        inter       = ch >= 8'h20 && ch <= 8'h2f;
        param       = ch >= 8'h30 && ch <= 8'h3f;
        fin         = ch >= 8'h40 && ch <= 8'h7e;
        plain_param = (ch >= 8'h30 && ch <= 8'h39) || ch == 8'h3b;
        case (mode)
            MODE_GROUND: begin
                push_event(EV_PRINT, ch, 1'b1, 1'b0);
            end
            MODE_DCS: begin
                if (inter) begin
                    buffer_byte(ch);
                    enter_mode(MODE_DCS_INT);
                end else if (ch == CH_COLON) begin
                    enter_mode(MODE_DCS_IGN);
                end else if (param) begin
                    buffer_byte(ch);
                    enter_mode(MODE_DCS_PAR);
                end else if (fin) begin
                    buffer_byte(ch);
                    enter_mode(MODE_DCS_PASS);
                end
            end
            MODE_DCS_INT: begin
                if (inter) begin
                    buffer_byte(ch);
                end else if (param) begin
                    enter_mode(MODE_DCS_IGN);
                end else if (fin) begin
                    buffer_byte(ch);
                    enter_mode(MODE_DCS_PASS);
                end
            end
            MODE_DCS_PAR: begin
                if (inter) begin
                    buffer_byte(ch);
                    enter_mode(MODE_DCS_INT);
                end else if (plain_param) begin
                    buffer_byte(ch);
                end else if (param) begin
                    enter_mode(MODE_DCS_IGN);
                end else if (fin) begin
                    buffer_byte(ch);
                    enter_mode(MODE_DCS_PASS);
                end
            end
            MODE_DCS_PASS: begin
                if (ch != CH_DEL)
                    push_event(EV_DCS_BYTE, ch, 1'b1, 1'b0);
            end
            MODE_OSC: begin
                if (!ctl)
                    buffer_byte(ch);
            end
            MODE_CSI: begin
                if (ctl) begin
                    push_event(EV_PRINT, ch, 1'b1, 1'b0);
                end else if (inter) begin
                    buffer_byte(ch);
                    enter_mode(MODE_CSI_INT);
                end else if (ch == CH_COLON) begin
                    enter_mode(MODE_CSI_IGN);
                end else if (param) begin
                    buffer_byte(ch);
                    enter_mode(MODE_CSI_PAR);
                end else if (fin) begin
                    push_event(EV_CSI, ch, 1'b1, 1'b0);
                    enter_mode(MODE_GROUND);
                end
            end
            MODE_CSI_INT: begin
                if (ctl)
                    push_event(EV_PRINT, ch, 1'b1, 1'b0);
                else if (inter)
                    buffer_byte(ch);
                else if (param)
                    enter_mode(MODE_CSI_IGN);
                else if (fin)
                    finish_csi(ch);
            end
            MODE_CSI_PAR: begin
                if (ctl) begin
                    push_event(EV_PRINT, ch, 1'b1, 1'b0);
                end else if (inter) begin
                    buffer_byte(ch);
                    enter_mode(MODE_CSI_INT);
                end else if (plain_param) begin
                    buffer_byte(ch);
                end else if (param) begin
                    enter_mode(MODE_CSI_IGN);
                end else if (fin) begin
                    finish_csi(ch);
                end
            end
            MODE_CSI_IGN: begin
                if (ctl)
                    push_event(EV_PRINT, ch, 1'b1, 1'b0);
                else if (fin || ch >= 8'h80)
                    enter_mode(MODE_GROUND);
            end
            default: begin
            end
        endcase
    endtask

    task automatic predict_request(input logic [7:0] ch);
        parse_event_t tail;
        request_events.delete();
        if (ch == CH_ESC) begin
            esc_seen = 1'b1;
        end else if (esc_seen) begin
            esc_seen = 1'b0;
            if (ch == CH_DCS)
                enter_mode(MODE_DCS);
            else if (ch == CH_CSI)
                enter_mode(MODE_CSI);
            else if (ch == CH_OSC)
                enter_mode(MODE_OSC);
            else
                enter_mode(MODE_GROUND);
        end else begin
            if (ch == CH_CAN || ch == CH_SUB)
                enter_mode(MODE_GROUND);
            mode_byte(ch);
        end
        if (request_events.size() > 0) begin
            tail = request_events.pop_back();
            tail.last = 1'b1;
            request_events.push_back(tail);
        end
        foreach (request_events[i])
            expected_events.push_back(request_events[i]);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            o_fail_count = o_fail_count + 1;
        end
    endtask

    task automatic check_result();
        parse_event_t want;
        if (expected_events.size() == 0) begin
            $error("unexpected result: event_kind %0d, data_byte %0h", i_event_kind, i_data_byte);
            o_fail_count = o_fail_count + 1;
        end else begin
            want = expected_events.pop_front();
            check_field("event_kind", 8'(want.kind), 8'(i_event_kind));
            check_field("data_byte", want.data, i_data_byte);
            check_field("byte_valid", 8'(want.has_byte), 8'(i_byte_valid));
            check_field("last_of_run", 8'(want.last), 8'(i_last_of_run));
            check_field("string_overflow", 8'(want.overflow), 8'(i_string_overflow));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode     = MODE_GROUND;
            esc_seen = 1'b0;
            clear_string();
            expected_events.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                predict_request(i_input_byte);
            if (i_out_valid && !i_out_stall)
                check_result();
        end
        o_pending <= expected_events.size();
    end

endmodule

// ----- bench/vt_escape_sequence_parser_test.sv -----
// Testbench top of the escape sequence parser: stimulus, receiver stalls and the verdict.
`timescale 1ns / 1ps

module vt_escape_sequence_parser_test import vesp_pkg::*;;

    // The random part stops once this many requests have been accepted.
    localparam int TARGET_ITEMS = 400;
    // Far above the slowest correct run: every request closing a full string while
    // the receiver stalls at its longest, plus the sender's longest gaps.
    localparam int CYCLE_LIMIT  = 3_000_000;
    // Length of the one long receiver hold-off that lets the parser fill up.
    localparam int HOLD_CYCLES  = 400;
    // Settle time after the last expected result, well above one string's streaming.
    localparam int DRAIN_CYCLES = 60;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       in_stall;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] ev_kind;
    logic [7:0] ev_byte;
    logic       ev_has_byte;
    logic       ev_last;
    logic       ev_ovf;

    int fail_count;
    int pending;
    int sent_count  = 0;
    int cycle_count = 0;

    // Handshake between the stimulus and the receiver process.
    bit hold_req = 1'b0;
    // While set, the sender or the receiver runs without any idle cycles.
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;

    always #5 clk = ~clk;

    vt_escape_sequence_parser dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_input_byte     (in_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_event_kind     (ev_kind),
        .o_data_byte      (ev_byte),
        .o_byte_valid     (ev_has_byte),
        .o_last_of_run    (ev_last),
        .o_string_overflow(ev_ovf)
    );

    esc_parser_checker u_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_input_byte     (in_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_event_kind     (ev_kind),
        .i_data_byte      (ev_byte),
        .i_byte_valid     (ev_has_byte),
        .i_last_of_run    (ev_last),
        .i_string_overflow(ev_ovf),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // String payload byte. Escape, cancel and substitute are left out here so that the
    // sequence runs to its intended end; the noise requests supply those bytes.
    function automatic logic [7:0] payload_byte();
        logic [7:0] b;
        do begin
            if ($urandom_range(0, 9) == 0)
                b = 8'($urandom_range(8'h00, 8'h1f));
            else
                b = 8'($urandom_range(8'h20, 8'hff));
        end while (b == CH_ESC || b == CH_CAN || b == CH_SUB);
        return b;
    endfunction

    function automatic logic [7:0] param_byte();
        if ($urandom_range(0, 3) == 0)
            return 8'h3b;
        return 8'($urandom_range(8'h30, 8'h39));
    endfunction

    // Offers one request and returns in the step in which it was accepted, or after the
    // idle gap that follows it. Valid stays high when the next request follows at once,
    // so it is never lowered and raised again within one step.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Ends a DCS or OSC string: mostly the string terminator, sometimes cancel or
    // substitute, an escape with some other byte, or nothing at all so that the bytes
    // stay behind as a stale buffer for the next sequence.
    task automatic close_string();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) begin
            send_byte(CH_ESC);
            send_byte(8'h5c);
        end else if (r < 8) begin
            send_byte(($urandom_range(0, 1) == 0) ? CH_CAN : CH_SUB);
        end else if (r < 9) begin
            send_byte(CH_ESC);
            send_byte(8'($urandom));
        end
    endtask

    task automatic send_text();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7e)));
    endtask

    // A control sequence with random content. Now and then it carries a control byte,
    // a private marker, an intermediate, a colon or a parameter string long enough to
    // overflow the buffer, and a few are left without their final byte.
    task automatic send_csi();
        int n;
        send_byte(CH_ESC);
        send_byte(CH_CSI);
        if ($urandom_range(0, 9) == 0)
            send_byte(8'($urandom_range(8'h00, 8'h1f)));
        if ($urandom_range(0, 7) == 0)
            send_byte(8'($urandom_range(8'h3c, 8'h3f)));
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 5);
        repeat (n) send_byte(param_byte());
        if ($urandom_range(0, 5) == 0)
            send_byte(8'($urandom_range(8'h20, 8'h2f)));
        if ($urandom_range(0, 11) == 0)
            send_byte(CH_COLON);
        if ($urandom_range(0, 19) != 0)
            send_byte(8'($urandom_range(8'h40, 8'h7e)));
    endtask

    task automatic send_dcs();
        int n;
        send_byte(CH_ESC);
        send_byte(CH_DCS);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 3);
        repeat (n) send_byte(param_byte());
        if ($urandom_range(0, 5) == 0)
            send_byte(8'($urandom_range(8'h20, 8'h2f)));
        if ($urandom_range(0, 9) == 0)
            send_byte(CH_COLON);
        send_byte(8'($urandom_range(8'h40, 8'h7e)));
        n = $urandom_range(0, 10);
        repeat (n) send_byte(payload_byte());
        close_string();
    endtask

    task automatic send_osc();
        int n;
        send_byte(CH_ESC);
        send_byte(CH_OSC);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 12);
        repeat (n) send_byte(payload_byte());
        close_string();
    endtask

    // Arbitrary bytes, sometimes behind an escape, to break sequences at random points.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 9) < 3)
            send_byte(CH_ESC);
        repeat (n) send_byte(8'($urandom));
    endtask

    // Receiver: random stalls of mixed length, quiet stretches without stalls, and one
    // long hold-off on request while the sender keeps offering requests.
    initial begin : receiver
        int n;
        @(posedge clk);
        forever begin
            if (hold_req) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                n = rx_quiet ? 0 : pick_gap();
                if (n > 0) begin
                    out_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if ($urandom_range(0, 19) == 0)
                rx_quiet = !rx_quiet;
        end
    end

    // Hard stop in case the parser hangs or results go missing.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int pick;
        bit hold_done;
        hold_done = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Print of both byte extremes in ground.
        send_byte(8'h00); send_byte(8'hff);
        // A final byte straight after the introducer is a one-byte CSI string.
        send_byte(CH_ESC); send_byte(CH_CSI); send_byte(8'h6d);
        // Private marker; a control byte inside is printed in place and
        // the final byte stays at the end of the string.
        send_byte(CH_ESC); send_byte(CH_CSI); send_byte(8'h3f); send_byte(8'h0a);
        send_byte(8'h68);
        // A colon sends CSI to its ignore mode; a control byte is still printed there and
        // a high byte returns to ground without output.
        send_byte(CH_ESC); send_byte(CH_CSI); send_byte(CH_COLON); send_byte(8'h0d);
        send_byte(8'h80);
        // DCS header, a payload byte, a dropped DEL, and substitute, which closes the
        // passthrough with its end mark and is then printed.
        send_byte(CH_ESC); send_byte(CH_DCS); send_byte(8'h71); send_byte(8'h41);
        send_byte(CH_DEL); send_byte(CH_SUB);
        // OSC with a dropped control byte, reentered from itself, then closed empty.
        send_byte(CH_ESC); send_byte(CH_OSC); send_byte(8'h30); send_byte(8'h07);
        send_byte(CH_ESC); send_byte(CH_OSC); send_byte(CH_ESC); send_byte(8'h5c);

        // Random part: mostly well-formed sequences with random content, the rest text
        // and noise. Partway through, the receiver holds off for a long stretch.
        while (sent_count < TARGET_ITEMS) begin
            if (!hold_done && sent_count > 150) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if ($urandom_range(0, 9) == 0)
                tx_quiet = !tx_quiet;
            pick = $urandom_range(0, 99);
            if (pick < 22)
                send_text();
            else if (pick < 48)
                send_csi();
            else if (pick < 67)
                send_dcs();
            else if (pick < 86)
                send_osc();
            else
                send_noise();
        end
        in_valid <= 1'b0;

        // Let the count of outstanding results catch up with the last request, then wait
        // for every expected result and a little longer to catch any extra one.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
design/vesp_pkg.sv
design/vesp_ram.sv
design/vesp_dp.sv
design/vesp_ctrl.sv
design/vt_escape_sequence_parser.sv
bench/esc_parser_checker.sv
bench/vt_escape_sequence_parser_test.sv
